// ===== src/xcfr_pkg.sv =====
`default_nettype none

package xcfr_pkg;

  // default for the largest number of data bytes in one frame
  localparam int MAX_DATA_BYTES_DEF = 32;

  // start, command, length, checksum and end
  localparam int FRAME_OVERHEAD = 5;
  // start, command and length come before the data
  localparam int HEADER_BYTES = 3;

  // marker values after reset
  localparam logic [7:0] START_MARKER_RESET = 8'hAA;
  localparam logic [7:0] END_MARKER_RESET   = 8'h55;

  // configuration register indexes
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // result kinds
  localparam logic KIND_CONTENT  = 1'b0;
  localparam logic KIND_CHECKSUM = 1'b1;

  // one closed frame that produces results
  typedef struct packed {
    logic       err;
    logic [7:0] command;
    logic [7:0] length;
    logic       bank;
  } frame_desc_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/xcfr_queue.sv =====
`default_nettype none

module xcfr_queue
  import xcfr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  frame_desc_t push_desc,
  input  wire         pop,
  output frame_desc_t head,
  output logic        head_valid,
  output logic        full
);

  // two entries, written and read in turn
  frame_desc_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  // entry writes
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head       = entry[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

endmodule

`default_nettype wire

// ===== src/xcfr_front.sv =====
`default_nettype none

module xcfr_front
  import xcfr_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
)
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [7:0]          cfg_data,
  input  wire                 rx_valid,
  output logic                rx_ready,
  input  wire  [7:0]          rx_byte,
  input  wire                 q_full,
  output logic                push,
  output frame_desc_t         push_desc,
  output logic                st_we,
  output logic [IW:0]         st_addr,
  output logic [7:0]          st_data
);

  localparam int CW = $clog2(MAX_DATA_BYTES + FRAME_OVERHEAD + 1);

  logic [7:0]    start_marker;
  logic [7:0]    end_marker;
  logic          in_frame;
  logic [CW-1:0] byte_count;
  logic [7:0]    frame_command;
  logic [7:0]    length_field;
  logic [7:0]    xor_sum;
  logic          bank;

  logic          take;
  logic [CW-1:0] count_next;
  logic          is_end;
  logic          frame_ok;
  logic          overflow;
  logic          is_data;

  // marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data;
        REG_END_MARKER:   end_marker   <= cfg_data;
        default:          start_marker <= start_marker;
      endcase
    end
  end

  // hold off while the queue holds two closed frames
  assign rx_ready = ~q_full;
  assign take     = rx_valid & rx_ready;

  // classify the word
  assign count_next = byte_count + CW'(1);
  assign is_end     = (rx_byte == end_marker);
  assign frame_ok   = ({1'b0, length_field} <= 9'(MAX_DATA_BYTES)) &&
                      (9'(count_next) == ({1'b0, length_field} + 9'(FRAME_OVERHEAD)));
  assign overflow   = (count_next >= CW'(MAX_DATA_BYTES + FRAME_OVERHEAD));
  assign is_data    = (byte_count >= CW'(HEADER_BYTES)) &&
                      (byte_count < CW'(HEADER_BYTES + MAX_DATA_BYTES));

  // closed frame goes to the back end
  assign push                = take & in_frame & is_end & frame_ok;
  assign push_desc.err       = (xor_sum != 8'd0);
  assign push_desc.command   = frame_command;
  assign push_desc.length    = length_field;
  assign push_desc.bank      = bank;

  // data byte into the current bank
  assign st_we   = take & in_frame & ~is_end & ~overflow & is_data;
  assign st_addr = {bank, IW'(byte_count - CW'(HEADER_BYTES))};
  assign st_data = rx_byte;

  // frame collection
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_count    <= '0;
      frame_command <= 8'd0;
      length_field  <= 8'd0;
      xor_sum       <= 8'd0;
      bank          <= 1'b0;
    end else if (take) begin
      if (!in_frame) begin
        if (rx_byte == start_marker) begin
          in_frame      <= 1'b1;
          byte_count    <= CW'(1);
          frame_command <= 8'd0;
          length_field  <= 8'd0;
          xor_sum       <= 8'd0;
        end
      end else if (is_end || overflow) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
        // a data frame leaves its bank to the back end
        if (push && (xor_sum == 8'd0) && (length_field != 8'd0)) begin
          bank <= ~bank;
        end
      end else begin
        byte_count <= count_next;
        xor_sum    <= xor_sum ^ rx_byte;
        if (byte_count == CW'(1)) begin
          frame_command <= rx_byte;
        end
        if (byte_count == CW'(2)) begin
          length_field <= rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/xcfr_back.sv =====
`default_nettype none

module xcfr_back
  import xcfr_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
)
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 st_we,
  input  wire  [IW:0]         st_addr,
  input  wire  [7:0]          st_data,
  input  frame_desc_t         head,
  input  wire                 head_valid,
  output logic                pop,
  output logic                res_valid,
  input  wire                 res_ready,
  output logic                kind,
  output logic [7:0]          command,
  output logic [5:0]          data_len,
  output logic [4:0]          data_index,
  output logic [7:0]          data_byte,
  output logic                has_data,
  output logic                last
);

  // two banks of frame data
  logic [7:0]  store [2**(IW+1)];
  logic [7:0]  rd_data;
  logic        rd_en;

  back_state_t state;
  back_state_t state_next;
  logic [IW-1:0] idx;
  logic        head_data;
  logic        head_last;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_addr] <= st_data;
    end
    if (rd_en) begin
      rd_data <= store[{head.bank, idx}];
    end
  end

  assign head_data = ~head.err & (head.length != 8'd0);
  assign head_last = ~head_data | ((8'(idx) + 8'd1) == head.length);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = head_data ? BK_FETCH : BK_SHOW;
        end
      end
      BK_FETCH: state_next = BK_SHOW;
      BK_SHOW: begin
        if (res_ready) begin
          state_next = head_last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rd_en     = 1'b0;
    res_valid = 1'b0;
    pop       = 1'b0;
    case (state)
      BK_FETCH: rd_en = 1'b1;
      BK_SHOW: begin
        res_valid = 1'b1;
        pop       = res_ready & head_last;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // state and data index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        idx <= '0;
      end else if ((state == BK_SHOW) && res_ready && !head_last) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // result word
  assign kind       = head.err ? KIND_CHECKSUM : KIND_CONTENT;
  assign command    = head.command;
  assign data_len   = head.length[5:0];
  assign has_data   = head_data;
  assign data_index = head_data ? 5'(idx) : 5'd0;
  assign data_byte  = head_data ? rd_data : 8'd0;
  assign last       = head_last;

endmodule

`default_nettype wire

// ===== src/xor_checked_frame_receiver_top.sv =====
`default_nettype none

// Frame receiver for marker-delimited byte frames: start marker, command,
// length, length data bytes, XOR checksum of command, length and data, end
// marker. The front end takes a received byte while rx_valid and rx_ready
// are both high. A good frame comes out as one word per data byte (one word
// with has_data low if it has no data), a checksum failure as one word with
// kind set; frames of wrong size, too long or overflowing are dropped. For
// each data word the back end reads the store, then shows the word until
// res_ready takes it; error and empty frames skip the store read. Data sits
// in two store banks; the front end keeps collecting while fewer than two
// closed frames wait and stalls rx_ready only when two wait. Marker registers
// are written through cfg_we/cfg_index/cfg_data and act on the next byte.
module xor_checked_frame_receiver_top
  import xcfr_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire  [7:0] cfg_data,
  input  wire        rx_valid,
  output logic       rx_ready,
  input  wire  [7:0] rx_byte,
  output logic       res_valid,
  input  wire        res_ready,
  output logic       kind,
  output logic [7:0] command,
  output logic [5:0] data_len,
  output logic [4:0] data_index,
  output logic [7:0] data_byte,
  output logic       has_data,
  output logic       last
);

  localparam int IW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic        q_full;
  logic        push;
  frame_desc_t push_desc;
  frame_desc_t head;
  logic        head_valid;
  logic        pop;
  logic        st_we;
  logic [IW:0] st_addr;
  logic [7:0]  st_data;

  // byte collection and frame checks
  xcfr_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data)
  );

  // closed frames waiting for output
  xcfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // result emission
  xcfr_back #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .st_we      (st_we),
    .st_addr    (st_addr),
    .st_data    (st_data),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .kind       (kind),
    .command    (command),
    .data_len   (data_len),
    .data_index (data_index),
    .data_byte  (data_byte),
    .has_data   (has_data),
    .last       (last)
  );

endmodule

`default_nettype wire
